[hw/rtl/nfa_epsilon_removal_unit_macros.svh]
// Assertion macros shared by the epsilon removal unit RTL.
// Every macro expects signals named clk and rst_n in the calling scope.
`ifndef NFA_EPSILON_REMOVAL_UNIT_MACROS_SVH
`define NFA_EPSILON_REMOVAL_UNIT_MACROS_SVH

// Check an expression at every clock edge out of reset.
`define NER_ASSERT_COMB(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition is followed by another one on the next edge.
`define NER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/nfa_er_pkg.sv]
// Types and constants of the epsilon removal unit.
// No dependencies; imported by every module of the block but nfa_er_ram.
`default_nettype none

package nfa_er_pkg;

  localparam int KIND_W     = 2;
  localparam int ST_W       = 3;
  localparam int SYM_W      = 3;
  localparam int ROW_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD_EPS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SYM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 1'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol_index;
    logic [ST_W-1:0]   row_state;
    logic [ROW_W-1:0]  row_targets;
  } in_pkt_t;

  typedef struct packed {
    logic [ST_W-1:0]  from_state;
    logic [SYM_W-1:0] on_symbol;
    logic [ROW_W-1:0] next_states;
    logic             last;
  } out_pkt_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;   // input channel open, apply load transactions
    logic init;   // seed closures from the epsilon rows
    logic warsh;  // one Warshall pivot step
    logic issue;  // issue one symbol row read
    logic emit;   // load one result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic compute_req;
    logic k_last;
    logic j_last;
    logic res_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/nfa_epsilon_removal_unit.sv]
// Top level of the NFA epsilon removal unit.
// Depends on nfa_er_pkg, nfa_er_ctrl and nfa_er_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   cycle while in_stall is low: load an epsilon row, load a symbol transition
//   row, or compute. Load transactions produce no result. A compute
//   transaction seeds the closure rows, runs one Warshall pivot per state,
//   then walks states (outer) and symbols (inner). Each result needs one
//   symbol store read per state on the single RAM read port, a wait for the
//   last read to land, and an emit. in_stall stays high for the whole of a
//   run.
//   Results leave through an output register (out_valid / out_stall /
//   out_data); last marks the final result of a run. While the receiver stalls
//   a valid result, the walk waits in its emit step and the register holds it.
//   Configuration (cfg_we / cfg_index / cfg_data) writes num_states (index 0)
//   or num_symbols (index 1); do so only while the block is idle (not enforced).
//   Reset: synchronous, active low; both counts return to 8 and all row
//   stores read as zero at once, with no clearing pass.
`default_nettype none

module nfa_epsilon_removal_unit
  import nfa_er_pkg::*;
#(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_pkt_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_pkt_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the phase, issues at most one command per cycle.
  nfa_er_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Stores, closure rows, counters and the output register.
  nfa_er_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the input channel whenever the sequencer is busy with a run.
  assign in_stall = !cmd.take;

endmodule

`default_nettype wire

[hw/rtl/nfa_er_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nfa_er_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/nfa_er_ctrl.sv]
// Sequencer of the epsilon removal unit: load, closure and emit phases.
// Depends on nfa_er_pkg and the assertion macro header.
`default_nettype none
`include "nfa_epsilon_removal_unit_macros.svh"

module nfa_er_ctrl
  import nfa_er_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_WARSH = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.compute_req) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_WARSH;
      end
      ST_WARSH: begin
        cmd.warsh = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        if (sts.j_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last row read lands in the accumulator
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.res_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `NER_ASSERT_COMB(a_cmd_onehot, $onehot0({cmd.take, cmd.init, cmd.warsh, cmd.issue, cmd.emit}), "more than one command active")
  `NER_ASSERT_COMB(a_emit_free, !cmd.emit || sts.out_free, "result emitted into a busy output register")
  `NER_ASSERT_NEXT(a_warsh_done, (state_r == ST_WARSH) && sts.k_last, state_r == ST_READ, "closure phase did not end after last pivot")

endmodule

`default_nettype wire

[hw/rtl/nfa_er_dp.sv]
// Datapath of the epsilon removal unit: row stores, closure rows,
// walk counters, reach accumulator and output register.
// Depends on nfa_er_pkg, nfa_er_ram and the assertion macro header.
`default_nettype none
`include "nfa_epsilon_removal_unit_macros.svh"

module nfa_er_dp
  import nfa_er_pkg::*;
#(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire in_pkt_t               in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output out_pkt_t                   out_data,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  localparam int STW   = $clog2(MAX_STATES);
  localparam int CNW   = $clog2(MAX_STATES + 1);
  localparam int SYW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CSW   = $clog2(MAX_SYMBOLS + 1);
  localparam int DEPTH = MAX_SYMBOLS * MAX_STATES;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_DATA_W-1:0] ns_r;
  logic [CFG_DATA_W-1:0] nsym_r;
  logic [MAX_STATES-1:0] eps_r  [MAX_STATES];
  logic [MAX_STATES-1:0] clos_r [MAX_STATES];
  logic [MAX_STATES-1:0] clos_nxt [MAX_STATES];
  logic [DEPTH-1:0]      vld_r;
  logic [STW-1:0]        k_r;
  logic [STW-1:0]        j_r;
  logic [STW-1:0]        s_r;
  logic [SYW-1:0]        a_r;
  logic [MAX_STATES-1:0] reach_r;
  logic [MAX_STATES-1:0] reach_nxt;
  logic                  rd_pend_r;
  logic [STW-1:0]        rd_j_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;
  out_pkt_t              out_pkt_r;

  logic [CNW-1:0]        n_eff;
  logic [CSW-1:0]        a_eff;
  logic [MAX_STATES-1:0] live;
  logic [MAX_STATES-1:0] targets;
  logic [MAX_STATES-1:0] spread;
  logic [MAX_STATES-1:0] rd_data;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  accept;
  logic                  eps_we;
  logic                  sym_we;
  logic                  s_last;
  logic                  a_last;

  // Effective counts: zero acts as one, overflow clamps to the maximum.
  always_comb begin
    if (ns_r == '0) begin
      n_eff = CNW'(1);
    end else if (ns_r > CFG_DATA_W'(MAX_STATES)) begin
      n_eff = CNW'(MAX_STATES);
    end else begin
      n_eff = CNW'(ns_r);
    end
    if (nsym_r == '0) begin
      a_eff = CSW'(1);
    end else if (nsym_r > CFG_DATA_W'(MAX_SYMBOLS)) begin
      a_eff = CSW'(MAX_SYMBOLS);
    end else begin
      a_eff = CSW'(nsym_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      live[i] = (i < int'(n_eff));
    end
  end

  assign accept  = in_valid && cmd.take;
  assign targets = in_data.row_targets[MAX_STATES-1:0];
  assign eps_we  = accept && (in_data.kind == KIND_LOAD_EPS) &&
                   (int'(in_data.row_state) < MAX_STATES);
  assign sym_we  = accept && (in_data.kind == KIND_LOAD_SYM) &&
                   (int'(in_data.row_state) < MAX_STATES) &&
                   (int'(in_data.symbol_index) < MAX_SYMBOLS);
  assign wr_addr = AW'(int'(in_data.symbol_index) * MAX_STATES + int'(in_data.row_state));
  assign rd_addr = AW'(int'(a_r) * MAX_STATES + int'(j_r));

  nfa_er_ram #(
    .WIDTH (MAX_STATES),
    .DEPTH (DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (wr_addr),
    .wdata (targets),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Closure rows: seed with the epsilon rows, then one pivot per step.
  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      clos_nxt[i] = clos_r[i];
      if (cmd.init) begin
        clos_nxt[i] = live[i] ?
          ((eps_r[i] & live) | ({{(MAX_STATES-1){1'b0}}, 1'b1} << i)) : '0;
      end else if (cmd.warsh && clos_r[i][k_r]) begin
        clos_nxt[i] = clos_r[i] | clos_r[k_r];
      end
    end
  end

  // Accumulate symbol rows of the states in the current closure.
  always_comb begin
    reach_nxt = reach_r;
    if (cmd.init || cmd.emit) begin
      reach_nxt = '0;
    end else if (rd_pend_r && rd_vld_r && clos_r[s_r][rd_j_r]) begin
      reach_nxt = reach_r | (rd_data & live);
    end
  end

  always_comb begin
    spread = '0;
    for (int m = 0; m < MAX_STATES; m++) begin
      if (reach_r[m]) begin
        spread = spread | clos_r[m];
      end
    end
  end

  assign s_last = (CNW'(s_r) + CNW'(1)) == n_eff;
  assign a_last = (CSW'(a_r) + CSW'(1)) == a_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r        <= CFG_COUNT_RESET;
      nsym_r      <= CFG_COUNT_RESET;
      vld_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STATES; i++) begin
        eps_r[i]  <= '0;
        clos_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_STATES:  ns_r   <= cfg_data;
          CFG_NUM_SYMBOLS: nsym_r <= cfg_data;
          default: ;
        endcase
      end
      if (eps_we) begin
        eps_r[in_data.row_state[STW-1:0]] <= targets;
      end
      if (sym_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      for (int i = 0; i < MAX_STATES; i++) begin
        clos_r[i] <= clos_nxt[i];
      end
      rd_pend_r <= cmd.issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk counters and payload; no reset needed, init seeds the counters.
  always_ff @(posedge clk) begin
    reach_r <= reach_nxt;
    if (cmd.issue) begin
      rd_j_r   <= j_r;
      rd_vld_r <= vld_r[rd_addr];
    end
    if (cmd.init) begin
      k_r <= '0;
      j_r <= '0;
      s_r <= '0;
      a_r <= '0;
    end
    if (cmd.warsh) begin
      k_r <= k_r + STW'(1);
    end
    if (cmd.issue) begin
      j_r <= j_r + STW'(1);
    end
    if (cmd.emit) begin
      out_pkt_r.from_state  <= ST_W'(s_r);
      out_pkt_r.on_symbol   <= SYM_W'(a_r);
      out_pkt_r.next_states <= ROW_W'(spread);
      out_pkt_r.last        <= s_last && a_last;
      j_r <= '0;
      if (a_last) begin
        a_r <= '0;
        s_r <= s_last ? '0 : s_r + STW'(1);
      end else begin
        a_r <= a_r + SYW'(1);
      end
    end
  end

  assign sts.compute_req = in_valid && (in_data.kind == KIND_COMPUTE);
  assign sts.k_last      = (CNW'(k_r) + CNW'(1)) == n_eff;
  assign sts.j_last      = (CNW'(j_r) + CNW'(1)) == n_eff;
  assign sts.res_last    = s_last && a_last;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_pkt_r;

  `NER_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")
  `NER_ASSERT_NEXT(a_run_rewind, cmd.emit && s_last && a_last, (s_r == '0) && (a_r == '0), "walk counters not rewound after last result")
  `NER_ASSERT_COMB(a_no_read_on_load, !(cmd.issue && sym_we), "symbol store written during a walk")

endmodule

`default_nettype wire

[tb/nfa_epsilon_removal_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of nfa_epsilon_removal_unit: row loads, closure runs, count settings.
// Depends on nfa_er_pkg and the unit's RTL; holds its own scoreboard class and stimulus.

class eps_free_board;
  localparam int STATE_SLOTS  = 8;
  localparam int SYMBOL_SLOTS = 8;
  typedef bit [nfa_er_pkg::ROW_W-1:0] row_t;
  typedef bit [nfa_er_pkg::CFG_DATA_W-1:0] count_t;

  row_t   eps_rows [STATE_SLOTS];
  row_t   sym_rows [SYMBOL_SLOTS][STATE_SLOTS];
  count_t states_cfg  = nfa_er_pkg::CFG_COUNT_RESET;
  count_t symbols_cfg = nfa_er_pkg::CFG_COUNT_RESET;
  nfa_er_pkg::out_pkt_t moves_due [$];
  int     mismatches;

  function void set_counts(count_t states, count_t symbols);
    states_cfg  = states;
    symbols_cfg = symbols;
  endfunction

  // Zero acts as one, anything above the slot count as the slot count.
  static function int clamp_count(count_t v, int top);
    if (v == 0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function void take_request(nfa_er_pkg::in_pkt_t item);
    case (item.kind)
      nfa_er_pkg::KIND_LOAD_EPS: eps_rows[item.row_state] = item.row_targets;
      nfa_er_pkg::KIND_LOAD_SYM: sym_rows[item.symbol_index][item.row_state] = item.row_targets;
      nfa_er_pkg::KIND_COMPUTE:  predict_moves();
      default: ;
    endcase
  endfunction

  function void predict_moves();
    row_t closure [STATE_SLOTS];
    row_t live;
    row_t reach;
    row_t next;
    int   n;
    int   a;
    nfa_er_pkg::out_pkt_t move;
    n = clamp_count(states_cfg, STATE_SLOTS);
    a = clamp_count(symbols_cfg, SYMBOL_SLOTS);
    live = '0;
    for (int i = 0; i < n; i++) live[i] = 1'b1;
    for (int i = 0; i < STATE_SLOTS; i++) begin
      closure[i] = '0;
      if (i < n) begin
        closure[i] = eps_rows[i] & live;
        closure[i][i] = 1'b1;
      end
    end
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        if (closure[i][k]) closure[i] = closure[i] | closure[k];
    for (int s = 0; s < n; s++) begin
      for (int k = 0; k < a; k++) begin
        reach = '0;
        for (int j = 0; j < n; j++)
          if (closure[s][j]) reach = reach | (sym_rows[k][j] & live);
        next = '0;
        for (int m = 0; m < n; m++)
          if (reach[m]) next = next | closure[m];
        move.from_state  = nfa_er_pkg::ST_W'(s);
        move.on_symbol   = nfa_er_pkg::SYM_W'(k);
        move.next_states = next;
        move.last        = (s == n - 1) && (k == a - 1);
        moves_due.push_back(move);
      end
    end
  endfunction

  function void match_move(nfa_er_pkg::out_pkt_t got);
    nfa_er_pkg::out_pkt_t want;
    if (moves_due.size() == 0) begin
      $error("unexpected result: from_state %0d on_symbol %0d next_states %02h last %0b",
             got.from_state, got.on_symbol, got.next_states, got.last);
      mismatches++;
      return;
    end
    want = moves_due.pop_front();
    if (got.from_state !== want.from_state) begin
      $error("from_state: expected %0d, got %0d", want.from_state, got.from_state);
      mismatches++;
    end
    if (got.on_symbol !== want.on_symbol) begin
      $error("on_symbol: expected %0d, got %0d", want.on_symbol, got.on_symbol);
      mismatches++;
    end
    if (got.next_states !== want.next_states) begin
      $error("next_states: expected %02h, got %02h", want.next_states, got.next_states);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module nfa_epsilon_removal_unit_test;
  import nfa_er_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SEND_GAP_CAP  = 20;
  localparam int SETTLE_CYCLES = 32;    // covers a load still in flight after the last result
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
  localparam int QUIET_LIMIT   = 4000;  // cycles without any transaction before giving up
  localparam int SEGMENTS      = 11;
  localparam int SEG_ITEMS     = 28;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_pkt_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic     in_stall;
  logic     out_valid;
  out_pkt_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_used     = 1'b0;
  int hold_left     = 0;
  int quiet         = 0;

  eps_free_board board = new;

  always #5 clk = ~clk;

  nfa_epsilon_removal_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver: random stall, except for one long hold-off counted here.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result transaction against the oldest predicted move.
  always @(posedge clk) begin : result_check
    if (rst_n && out_valid && !out_stall) board.match_move(out_data);
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_pkt_t make_item(logic [KIND_W-1:0] kind, int sym, int row,
                                        logic [ROW_W-1:0] targets);
    in_pkt_t item;
    item.kind         = kind;
    item.symbol_index = SYM_W'(sym);
    item.row_state    = ST_W'(row);
    item.row_targets  = targets;
    return item;
  endfunction

  // Mostly row loads with random content, some closure runs, a little unused kind.
  function automatic in_pkt_t random_item();
    in_pkt_t item;
    int      pick;
    pick = $urandom_range(99);
    item.symbol_index = SYM_W'($urandom);
    item.row_state    = ST_W'($urandom);
    item.row_targets  = ROW_W'($urandom);
    if (pick < 4)
      item.kind = KIND_UNUSED;
    else if (pick < 16)
      item.kind = KIND_COMPUTE;
    else if (pick < 55)
      item.kind = KIND_LOAD_EPS;
    else
      item.kind = KIND_LOAD_SYM;
    return item;
  endfunction

  // Offer one transaction after a random gap; hold it until the block takes it.
  task automatic send(input in_pkt_t item);
    int gaps;
    gaps = 0;
    while (gaps < SEND_GAP_CAP && $urandom_range(99) < send_idle_pct) gaps++;
    if (gaps != 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_request(item);
  endtask

  // Drop valid, wait for every predicted move, then let a trailing load finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.moves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both counts back to back while the block is idle.
  task automatic configure(input logic [CFG_DATA_W-1:0] states,
                           input logic [CFG_DATA_W-1:0] symbols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_STATES;
    cfg_data  <= states;
    @(posedge clk);
    cfg_index <= CFG_NUM_SYMBOLS;
    cfg_data  <= symbols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_counts(states, symbols);
  endtask

  initial begin : stimulus
    in_pkt_t              item;
    int                   counted;
    logic [CFG_DATA_W-1:0] st;
    logic [CFG_DATA_W-1:0] sy;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct <= 73;

    // Stores come out of reset empty: every move at the default counts is empty.
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));
    // Extreme rows, including rows and bits beyond smaller state counts.
    send(make_item(KIND_LOAD_EPS, 0, 0, 8'hFF));
    send(make_item(KIND_LOAD_EPS, 0, 7, 8'h01));
    send(make_item(KIND_LOAD_EPS, 0, 3, 8'h00));
    send(make_item(KIND_LOAD_SYM, 0, 0, 8'h80));
    send(make_item(KIND_LOAD_SYM, 7, 7, 8'hFF));
    send(make_item(KIND_LOAD_SYM, 3, 5, 8'h55));
    send(make_item(KIND_LOAD_SYM, 7, 0, 8'hAA));
    // Unused kind must leave every store alone.
    send(make_item(KIND_UNUSED, 7, 7, 8'hFF));

    // Hold off the receiver during a run and keep offering loads behind it.
    hold_req <= 1'b1;
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));
    send(make_item(KIND_LOAD_EPS, 0, 1, 8'h02));
    send(make_item(KIND_LOAD_SYM, 1, 2, 8'h04));
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));

    // Small counts: bits at and above the state count must be ignored.
    configure(4'd3, 4'd2);
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));
    // Zero counts act as one.
    configure(4'd0, 4'd0);
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));
    // Counts above the maximum act as the maximum.
    configure(4'd15, 4'd9);
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));
    configure(4'd1, 4'd8);
    send(make_item(KIND_LOAD_SYM, 5, 0, 8'h01));
    send(make_item(KIND_COMPUTE, 0, 0, 8'h00));

    // Random segments: receiver sparse then sender sparse, then both at full rate.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin st = 4'd8;  sy = 4'd8;  end
        1: begin st = 4'd1;  sy = 4'd1;  end
        2: begin st = 4'd0;  sy = 4'd15; end
        3: begin st = 4'd15; sy = 4'd0;  end
        default: begin
          st = CFG_DATA_W'($urandom_range(15));
          sy = CFG_DATA_W'($urandom_range(15));
        end
      endcase
      configure(st, sy);
      if (seg < 4) begin
        send_idle_pct = 21;
        recv_idle_pct <= 73;
      end else if (seg < 8) begin
        send_idle_pct = 73;
        recv_idle_pct <= 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      counted = 0;
      while (counted < SEG_ITEMS) begin
        item = random_item();
        send(item);
        if (item.kind != KIND_UNUSED) counted++;
      end
    end

    drain();
    if (board.mismatches == 0 && board.moves_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/nfa_er_pkg.sv
hw/rtl/nfa_er_ram.sv
hw/rtl/nfa_er_ctrl.sv
hw/rtl/nfa_er_dp.sv
hw/rtl/nfa_epsilon_removal_unit.sv
tb/nfa_epsilon_removal_unit_test.sv
